// ===== src/rv32if_instruction_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// rv32if decoder assertion macros
// shared concurrent assertion wrappers for the decoder project
// ----------------------------------------------------------------------------
`ifndef RV32IF_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define RV32IF_INSTRUCTION_DECODER_TOP_MACROS_SVH

// property checked on every rising edge while out of reset
`define RV32IF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge while out of reset
`define RV32IF_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== src/rv32if_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32if decoder package
// opcode, funct7, operation and format codes shared by the decoder files
// ----------------------------------------------------------------------------
package rv32if_pkg;

  localparam int unsigned INSN_W = 32;

  typedef logic [INSN_W-1:0] insn_t;

  // major opcodes
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OP_IMM  = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_MISCMEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;
  localparam logic [6:0] OPC_LOAD_FP = 7'h07;
  localparam logic [6:0] OPC_STOR_FP = 7'h27;
  localparam logic [6:0] OPC_MADD    = 7'h43;
  localparam logic [6:0] OPC_MSUB    = 7'h47;
  localparam logic [6:0] OPC_NMSUB   = 7'h4B;
  localparam logic [6:0] OPC_NMADD   = 7'h4F;
  localparam logic [6:0] OPC_OP_FP   = 7'h53;

  // funct7 values
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] F7_FADD    = 7'h00;
  localparam logic [6:0] F7_FSUB    = 7'h04;
  localparam logic [6:0] F7_FMUL    = 7'h08;
  localparam logic [6:0] F7_FDIV    = 7'h0C;
  localparam logic [6:0] F7_FSQRT   = 7'h2C;
  localparam logic [6:0] F7_FSGNJ   = 7'h10;
  localparam logic [6:0] F7_FMINMAX = 7'h14;
  localparam logic [6:0] F7_FCVT_WS = 7'h60;
  localparam logic [6:0] F7_FMV_XW  = 7'h70;
  localparam logic [6:0] F7_FCMP    = 7'h50;
  localparam logic [6:0] F7_FCVT_SW = 7'h68;
  localparam logic [6:0] F7_FMV_WX  = 7'h78;

  typedef enum logic [6:0] {
    OP_NONE      = 7'd0,
    OP_LUI       = 7'd1,
    OP_AUIPC     = 7'd2,
    OP_JAL       = 7'd3,
    OP_JALR      = 7'd4,
    OP_BEQ       = 7'd5,
    OP_BNE       = 7'd6,
    OP_BLT       = 7'd7,
    OP_BGE       = 7'd8,
    OP_BLTU      = 7'd9,
    OP_BGEU      = 7'd10,
    OP_LB        = 7'd11,
    OP_LH        = 7'd12,
    OP_LW        = 7'd13,
    OP_LBU       = 7'd14,
    OP_LHU       = 7'd15,
    OP_SB        = 7'd16,
    OP_SH        = 7'd17,
    OP_SW        = 7'd18,
    OP_ADDI      = 7'd19,
    OP_SLTI      = 7'd20,
    OP_SLTIU     = 7'd21,
    OP_XORI      = 7'd22,
    OP_ORI       = 7'd23,
    OP_ANDI      = 7'd24,
    OP_SLLI      = 7'd25,
    OP_SRLI      = 7'd26,
    OP_SRAI      = 7'd27,
    OP_ADD       = 7'd28,
    OP_SUB       = 7'd29,
    OP_SLL       = 7'd30,
    OP_SLT       = 7'd31,
    OP_SLTU      = 7'd32,
    OP_XOR       = 7'd33,
    OP_SRL       = 7'd34,
    OP_SRA       = 7'd35,
    OP_OR        = 7'd36,
    OP_AND       = 7'd37,
    OP_FENCE     = 7'd38,
    OP_FENCE_I   = 7'd39,
    OP_ECALL     = 7'd40,
    OP_EBREAK    = 7'd41,
    OP_CSRRW     = 7'd42,
    OP_CSRRS     = 7'd43,
    OP_CSRRC     = 7'd44,
    OP_CSRRWI    = 7'd45,
    OP_CSRRSI    = 7'd46,
    OP_CSRRCI    = 7'd47,
    OP_FLW       = 7'd48,
    OP_FSW       = 7'd49,
    OP_FMADD_S   = 7'd50,
    OP_FMSUB_S   = 7'd51,
    OP_FNMSUB_S  = 7'd52,
    OP_FNMADD_S  = 7'd53,
    OP_FADD_S    = 7'd54,
    OP_FSUB_S    = 7'd55,
    OP_FMUL_S    = 7'd56,
    OP_FDIV_S    = 7'd57,
    OP_FSQRT_S   = 7'd58,
    OP_FSGNJ_S   = 7'd59,
    OP_FSGNJN_S  = 7'd60,
    OP_FSGNJX_S  = 7'd61,
    OP_FMIN_S    = 7'd62,
    OP_FMAX_S    = 7'd63,
    OP_FCVT_W_S  = 7'd64,
    OP_FCVT_WU_S = 7'd65,
    OP_FMV_X_W   = 7'd66,
    OP_FCLASS_S  = 7'd67,
    OP_FLE_S     = 7'd68,
    OP_FLT_S     = 7'd69,
    OP_FEQ_S     = 7'd70,
    OP_FCVT_S_W  = 7'd71,
    OP_FCVT_S_WU = 7'd72,
    OP_FMV_W_X   = 7'd73
  } op_t;

  typedef enum logic [3:0] {
    FMT_NONE = 4'd0,
    FMT_U    = 4'd1,
    FMT_J    = 4'd2,
    FMT_I    = 4'd3,
    FMT_B    = 4'd4,
    FMT_S    = 4'd5,
    FMT_R    = 4'd6,
    FMT_R4   = 4'd7,
    FMT_RF   = 4'd8
  } fmt_t;

  typedef struct packed {
    op_t  op;
    fmt_t fmt;
    logic recognized;
  } dec_res_t;

endpackage

// ===== src/rv32if_decode.sv =====
// ----------------------------------------------------------------------------
// rv32if instruction classifier
// combinational decode of one rv32i/rv32f word into operation and format
// ----------------------------------------------------------------------------
module rv32if_decode (
  input  rv32if_pkg::insn_t    insn,
  output rv32if_pkg::dec_res_t res
);
  import rv32if_pkg::*;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [4:0] rs2;
  logic [6:0] f7;
  op_t        op;
  fmt_t       fmt;

  assign opc = insn[6:0];
  assign f3  = insn[14:12];
  assign rs2 = insn[24:20];
  assign f7  = insn[31:25];

  always_comb begin
    op  = OP_NONE;
    fmt = FMT_NONE;
    case (opc)
      OPC_LUI: begin
        op  = OP_LUI;
        fmt = FMT_U;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        fmt = FMT_U;
      end
      OPC_JAL: begin
        op  = OP_JAL;
        fmt = FMT_J;
      end
      OPC_JALR: begin
        op  = OP_JALR;
        fmt = FMT_I;
      end
      OPC_BRANCH: begin
        fmt = FMT_B;
        case (f3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: op = OP_NONE;
        endcase
      end
      OPC_LOAD: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          default: op = OP_NONE;
        endcase
      end
      OPC_STORE: begin
        fmt = FMT_S;
        case (f3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          default: op = OP_NONE;
        endcase
      end
      OPC_OP_IMM: begin
        fmt = FMT_I;
        case (f3)
          3'd0: op = OP_ADDI;
          3'd1: op = OP_SLLI;
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: begin
            // right shifts report the register format
            fmt = FMT_R;
            if (f7 == F7_BASE) begin
              op = OP_SRLI;
            end else if (f7 == F7_ALT) begin
              op = OP_SRAI;
            end
          end
          3'd6:    op = OP_ORI;
          3'd7:    op = OP_ANDI;
          default: op = OP_NONE;
        endcase
      end
      OPC_OP: begin
        fmt = FMT_R;
        case (f3)
          3'd0: begin
            if (f7 == F7_BASE) begin
              op = OP_ADD;
            end else if (f7 == F7_ALT) begin
              op = OP_SUB;
            end
          end
          3'd1: op = OP_SLL;
          3'd2: op = OP_SLT;
          3'd3: op = OP_SLTU;
          3'd4: op = OP_XOR;
          3'd5: begin
            if (f7 == F7_BASE) begin
              op = OP_SRL;
            end else if (f7 == F7_ALT) begin
              op = OP_SRA;
            end
          end
          3'd6:    op = OP_OR;
          3'd7:    op = OP_AND;
          default: op = OP_NONE;
        endcase
      end
      OPC_MISCMEM: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    op = OP_FENCE;
          3'd1:    op = OP_FENCE_I;
          default: op = OP_NONE;
        endcase
      end
      OPC_SYSTEM: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    op = insn[20] ? OP_EBREAK : OP_ECALL;
          3'd1:    op = OP_CSRRW;
          3'd2:    op = OP_CSRRS;
          3'd3:    op = OP_CSRRC;
          3'd5:    op = OP_CSRRWI;
          3'd6:    op = OP_CSRRSI;
          3'd7:    op = OP_CSRRCI;
          default: op = OP_NONE;
        endcase
      end
      OPC_LOAD_FP: begin
        fmt = FMT_I;
        if (f3 == 3'd2) begin
          op = OP_FLW;
        end
      end
      OPC_STOR_FP: begin
        fmt = FMT_S;
        if (f3 == 3'd2) begin
          op = OP_FSW;
        end
      end
      // fused multiply-add: only the single-precision format is taken
      OPC_MADD: begin
        fmt = FMT_R4;
        if (f7[1:0] == 2'b00) begin
          op = OP_FMADD_S;
        end
      end
      OPC_MSUB: begin
        fmt = FMT_R4;
        if (f7[1:0] == 2'b00) begin
          op = OP_FMSUB_S;
        end
      end
      OPC_NMSUB: begin
        fmt = FMT_R4;
        if (f7[1:0] == 2'b00) begin
          op = OP_FNMSUB_S;
        end
      end
      OPC_NMADD: begin
        fmt = FMT_R4;
        if (f7[1:0] == 2'b00) begin
          op = OP_FNMADD_S;
        end
      end
      OPC_OP_FP: begin
        fmt = FMT_RF;
        case (f7)
          F7_FADD: op = OP_FADD_S;
          F7_FSUB: op = OP_FSUB_S;
          F7_FMUL: op = OP_FMUL_S;
          F7_FDIV: op = OP_FDIV_S;
          F7_FSQRT: begin
            if (rs2 == 5'd0) begin
              op = OP_FSQRT_S;
            end
          end
          F7_FSGNJ: begin
            fmt = FMT_R;
            case (f3)
              3'd0:    op = OP_FSGNJ_S;
              3'd1:    op = OP_FSGNJN_S;
              3'd2:    op = OP_FSGNJX_S;
              default: op = OP_NONE;
            endcase
          end
          F7_FMINMAX: begin
            case (f3)
              3'd0:    op = OP_FMIN_S;
              3'd1:    op = OP_FMAX_S;
              default: op = OP_NONE;
            endcase
          end
          F7_FCVT_WS: begin
            case (rs2)
              5'd0:    op = OP_FCVT_W_S;
              5'd1:    op = OP_FCVT_WU_S;
              default: op = OP_NONE;
            endcase
          end
          F7_FMV_XW: begin
            fmt = FMT_R;
            if (rs2 == 5'd0) begin
              case (f3)
                3'd0:    op = OP_FMV_X_W;
                3'd1:    op = OP_FCLASS_S;
                default: op = OP_NONE;
              endcase
            end
          end
          F7_FCMP: begin
            fmt = FMT_R;
            case (f3)
              3'd0:    op = OP_FLE_S;
              3'd1:    op = OP_FLT_S;
              3'd2:    op = OP_FEQ_S;
              default: op = OP_NONE;
            endcase
          end
          F7_FCVT_SW: begin
            case (rs2)
              5'd0:    op = OP_FCVT_S_W;
              5'd1:    op = OP_FCVT_S_WU;
              default: op = OP_NONE;
            endcase
          end
          F7_FMV_WX: begin
            fmt = FMT_R;
            if (rs2 == 5'd0 && f3 == 3'd0) begin
              op = OP_FMV_W_X;
            end
          end
          default: op = OP_NONE;
        endcase
      end
      default: begin
        op  = OP_NONE;
        fmt = FMT_NONE;
      end
    endcase
  end

  // an unrecognized word never reports a format
  assign res.op         = op;
  assign res.fmt        = (op == OP_NONE) ? FMT_NONE : fmt;
  assign res.recognized = (op != OP_NONE);

endmodule

// ===== src/rv32if_instruction_decoder_top.sv =====
// a request passes the input register and the result register, in that order, before its result is valid
// throughput: one request per cycle, limited only by the result side stalling
// the input register and the result register form a two-entry pipeline
// reset: synchronous active-low rst_n clears both valid flags; payload is not reset
// ----------------------------------------------------------------------------
// rv32if instruction decoder top
// registered rv32i/rv32f classifier with valid/stall handshakes
// ----------------------------------------------------------------------------
`include "rv32if_instruction_decoder_top_macros.svh"

module rv32if_instruction_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rv32if_pkg::insn_t in_instruction_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_op_code,
  output logic [3:0]        out_format_code,
  output logic              out_recognized
);
  import rv32if_pkg::*;

  logic     s1_v_r;
  logic     s1_v_nxt;
  insn_t    s1_insn_r;
  logic     s2_v_r;
  logic     s2_v_nxt;
  dec_res_t s2_res_r;
  dec_res_t dec_res;
  logic     in_take;
  logic     s2_load;
  logic     out_take;
  logic     out_consistent;

  rv32if_decode u_decode (
    .insn (s1_insn_r),
    .res  (dec_res)
  );

  assign out_take = s2_v_r && !out_stall;
  assign s2_load  = s1_v_r && (!s2_v_r || !out_stall);
  assign in_stall = s1_v_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (out_take) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_insn_r <= in_instruction_word;
    end
    if (s2_load) begin
      s2_res_r <= dec_res;
    end
  end

  assign out_valid       = s2_v_r;
  assign out_op_code     = s2_res_r.op;
  assign out_format_code = s2_res_r.fmt;
  assign out_recognized  = s2_res_r.recognized;

  assign out_consistent = (out_recognized == (out_op_code != OP_NONE)) &&
                          ((out_format_code == FMT_NONE) == !out_recognized);

  // a full pipeline with a stalled result must hold off new requests
  `RV32IF_ASSERT_IMPL(a_full_stalls, s1_v_r && s2_v_r && out_stall, in_stall, "taken while full")
  // an accepted request always lands in the input register
  `RV32IF_ASSERT_IMPL(a_take_fills, in_valid && !in_stall, ##1 s1_v_r, "accepted request lost")
  // a waiting request moves on when the result slot is free
  `RV32IF_ASSERT_IMPL(a_advance, s1_v_r && !s2_v_r, ##1 s2_v_r, "request did not advance")
  // recognized flag and format code agree with the operation code
  `RV32IF_ASSERT(a_rec_consistent, !out_valid || out_consistent, "inconsistent result")

endmodule
